/* rtl/ter_pkg.sv */
`default_nettype none
package ter_pkg;

	localparam int STORE_DEPTH = 256;
	localparam int FETCH_MAX   = 16;
	localparam int RESULT_CAP  = 16;
	localparam int FETCH_CAP   = (FETCH_MAX < RESULT_CAP) ? FETCH_MAX : RESULT_CAP;

	localparam int IDX_W = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int ROW_W = 24;
	localparam int LIM_W = 5;
	localparam int ORDER_SHIFT = 6;

	localparam logic [ROW_W-1:0] ROW_MAX = '1;

	// command codes
	localparam logic [2:0] FN_TICK   = 3'd0;
	localparam logic [2:0] FN_FETCH  = 3'd1;
	localparam logic [2:0] FN_ACTION = 3'd2;
	localparam logic [2:0] FN_INSERT = 3'd3;
	localparam logic [2:0] FN_DELETE = 3'd4;
	localparam logic [2:0] FN_REWIND = 3'd5;
	localparam logic [2:0] FN_CLEAR  = 3'd6;
	localparam logic [2:0] FN_READ   = 3'd7;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_BAD_IDX  = 3'd2;
	localparam logic [2:0] ST_INACTIVE = 3'd3;
	localparam logic [2:0] ST_NO_EVENT = 3'd4;

	// register indexes
	localparam logic REG_RECORD = 1'b0;
	localparam logic REG_PLAY   = 1'b1;

	// search modes of the cell chain
	localparam logic [1:0] SM_READ  = 2'd0;
	localparam logic [1:0] SM_SKIP  = 2'd1;
	localparam logic [1:0] SM_PLACE = 2'd2;

	// store update operations
	localparam logic [1:0] OP_HOLD   = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_INSERT = 2'd2;
	localparam logic [1:0] OP_REMOVE = 2'd3;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [7:0]       code;
		logic [7:0]       param;
		logic [6:0]       value;
	} event_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
		event_t           ev;
	} link_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [CNT_W-1:0] key;
		logic [ROW_W-1:0] row;
		logic [CNT_W-1:0] total;
		logic [1:0]       op;
		logic [IDX_W-1:0] pos;
		event_t           ev;
	} ctrl_t;

	typedef struct packed {
		logic [2:0]       status;
		logic             execute;
		event_t           ev;
		logic [CNT_W-1:0] count;
		logic [ROW_W-1:0] now;
		logic             last;
	} result_t;

endpackage
`default_nettype wire

/* rtl/ter_if.sv */
`default_nettype none
interface ter_in_if import ter_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [2:0]       func;
	logic [ROW_W-1:0] at_row;
	logic [7:0]       act_code;
	logic [7:0]       act_param;
	logic [6:0]       act_value;
	logic [7:0]       slot;
	logic             from_replay;
	logic [LIM_W-1:0] fetch_limit;

	modport source (output valid, func, at_row, act_code, act_param, act_value, slot,
		from_replay, fetch_limit, input ready);
	modport sink (input valid, func, at_row, act_code, act_param, act_value, slot,
		from_replay, fetch_limit, output ready);
endinterface

interface ter_out_if import ter_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [2:0]       status;
	logic             execute;
	logic [ROW_W-1:0] ev_row;
	logic [7:0]       ev_action;
	logic [7:0]       ev_param;
	logic [6:0]       ev_value;
	logic [8:0]       stored_count;
	logic [ROW_W-1:0] now_row;
	logic [17:0]      order_number;
	logic [5:0]       row_in_order;
	logic             last;

	modport source (output valid, status, execute, ev_row, ev_action, ev_param, ev_value,
		stored_count, now_row, order_number, row_in_order, last, input ready);
	modport sink (input valid, status, execute, ev_row, ev_action, ev_param, ev_value,
		stored_count, now_row, order_number, row_in_order, last, output ready);
endinterface

interface ter_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/ter_cell.sv */
`default_nettype none
module ter_cell import ter_pkg::*; (
	input  wire logic             clk,
	input  wire logic [IDX_W-1:0] cell_idx,
	input  wire ctrl_t            ctrl,
	input  wire event_t           left_ev,
	input  wire event_t           right_ev,
	input  wire link_t            link_in,
	output event_t                ev_q,
	output link_t                 link_q
);
	logic [CNT_W-1:0] my_pos;
	logic             below_total;
	logic             cond;

	assign my_pos      = CNT_W'(cell_idx);
	assign below_total = my_pos < ctrl.total;

	// local match for the running search
	always_comb begin
		case (ctrl.mode)
			SM_READ:  cond = (my_pos == ctrl.key);
			SM_SKIP:  cond = (my_pos >= ctrl.key) && (!below_total || ev_q.row >= ctrl.row);
			SM_PLACE: cond = below_total && (ev_q.row <= ctrl.row);
			default:  cond = 1'b0;
		endcase
	end

	// pass the search result toward cell zero
	always_ff @(posedge clk) begin
		if (ctrl.mode == SM_PLACE && link_in.hit) begin
			link_q <= link_in;
		end else if (cond) begin
			link_q <= '{hit: 1'b1, idx: cell_idx, ev: ev_q};
		end else begin
			link_q <= link_in;
		end
	end

	// hold, load or shift the stored event
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_WRITE: begin
				if (cell_idx == ctrl.pos) ev_q <= ctrl.ev;
			end
			OP_INSERT: begin
				if (cell_idx == ctrl.pos) ev_q <= ctrl.ev;
				else if (cell_idx > ctrl.pos) ev_q <= left_ev;
			end
			OP_REMOVE: begin
				if (cell_idx >= ctrl.pos) ev_q <= right_ev;
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

/* rtl/timestamped_event_recorder.sv */
// Timestamped event recorder.
// Commands arrive on ev_in (valid/ready); each transfer yields one result on
// ev_out, a fetch yields 1 to 16, the final one flagged by last. Registers
// record_enable (index 0) and play_enable (index 1) are written on cfg,
// which is always ready; write them only while the block is idle.
// The store is a chain of STORE_DEPTH cells. Each cycle every cell hands a
// search result to its lower neighbor, so a lookup settles at cell zero once
// it has crossed the whole chain; inserts and deletes then shift the cells
// from the target position upward together.
// Tick, action, rewind, clear and rejected commands answer in the transfer
// cycle (result registered and visible in the next cycle). Read, delete and
// insert first run a search through the cell chain. A fetch runs a pointer
// search, then one read search per event examined, and ends when the events
// run out, the limit is met or an event's row differs from the current row.
// One command is in flight at a time; ev_in is ready only when idle and the
// output register is free or being drained.
// Reset clears the row counter, replay pointer, event count and registers;
// store contents are undefined until written.
// A stalled receiver holds the result register and stalls the sequencer wherever it must emit a result.
`default_nettype none
module timestamped_event_recorder import ter_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	ter_in_if.sink    ev_in,
	ter_out_if.source ev_out,
	ter_cfg_if.sink   cfg
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_FETCH = 3'd2;

	logic [2:0]       state_q, state_d;
	logic [ROW_W-1:0] rc_q, rc_d;
	logic [CNT_W-1:0] ptr_q, ptr_d;
	logic [CNT_W-1:0] total_q, total_d;
	logic             rec_q, play_q;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0]       mode_q, mode_d;
	logic [CNT_W-1:0] key_q, key_d;
	logic [2:0]       func_q, func_d;
	event_t           item_q, item_d;
	logic [IDX_W-1:0] slot_q, slot_d;
	logic [LIM_W-1:0] lim_q, lim_d;
	logic [LIM_W-1:0] n_q, n_d;
	logic [CNT_W-1:0] rd_q, rd_d;
	event_t           held_q, held_d;
	logic             out_valid_q;
	result_t          res_q, res;
	logic             emit;
	logic             can_emit;
	logic             in_take;
	ctrl_t            ctrl;
	event_t           in_ev;
	event_t           act_ev;
	logic [LIM_W-1:0] lim_eff;
	link_t            head;
	logic [CNT_W-1:0] ins_pos;

	event_t cell_ev   [STORE_DEPTH];
	link_t  cell_link [STORE_DEPTH];

	assign can_emit = !out_valid_q || ev_out.ready;
	assign ev_in.ready = (state_q == S_IDLE) && can_emit;
	assign in_take = ev_in.valid && ev_in.ready;
	assign cfg.ready = 1'b1;

	assign in_ev  = '{row: ev_in.at_row, code: ev_in.act_code, param: ev_in.act_param,
		value: ev_in.act_value};
	assign act_ev = '{row: rc_q, code: ev_in.act_code, param: ev_in.act_param,
		value: ev_in.act_value};
	assign lim_eff = (ev_in.fetch_limit > LIM_W'(FETCH_CAP)) ? LIM_W'(FETCH_CAP)
		: ev_in.fetch_limit;
	assign head = cell_link[0];
	assign ins_pos = head.hit ? (CNT_W'(head.idx) + CNT_W'(1)) : '0;

	function automatic result_t mk_res(input logic [2:0] st, input logic ex, input event_t e,
		input logic [CNT_W-1:0] cn, input logic [ROW_W-1:0] nw, input logic ls);
		result_t r;
		r.status = st;
		r.execute = ex;
		r.ev = e;
		r.count = cn;
		r.now = nw;
		r.last = ls;
		return r;
	endfunction

	// sequence commands
	always_comb begin
		state_d = state_q;
		rc_d = rc_q;
		ptr_d = ptr_q;
		total_d = total_q;
		cnt_d = (cnt_q < CNT_W'(STORE_DEPTH)) ? cnt_q + CNT_W'(1) : cnt_q;
		mode_d = mode_q;
		key_d = key_q;
		func_d = func_q;
		item_d = item_q;
		slot_d = slot_q;
		lim_d = lim_q;
		n_d = n_q;
		rd_d = rd_q;
		held_d = held_q;
		emit = 1'b0;
		res = '0;
		ctrl.mode = mode_q;
		ctrl.key = key_q;
		ctrl.row = (mode_q == SM_SKIP) ? rc_q : item_q.row;
		ctrl.total = total_q;
		ctrl.op = OP_HOLD;
		ctrl.pos = '0;
		ctrl.ev = item_q;

		case (state_q)
			S_IDLE: begin
				if (in_take) begin
					func_d = ev_in.func;
					item_d = in_ev;
					slot_d = IDX_W'(ev_in.slot);
					lim_d = lim_eff;
					key_d = CNT_W'(ev_in.slot);
					cnt_d = '0;
					emit = 1'b1;
					case (ev_in.func)
						FN_TICK: begin
							if (play_q && rc_q != ROW_MAX) rc_d = rc_q + ROW_W'(1);
							res = mk_res(play_q ? ST_OK : ST_INACTIVE, 1'b0, '0, total_q,
								rc_d, 1'b1);
						end
						FN_FETCH: begin
							if (!play_q) begin
								res = mk_res(ST_INACTIVE, 1'b0, '0, total_q, rc_q, 1'b1);
							end else if (lim_eff == '0) begin
								res = mk_res(ST_NO_EVENT, 1'b0, '0, total_q, rc_q, 1'b1);
							end else begin
								emit = 1'b0;
								mode_d = SM_SKIP;
								key_d = ptr_q;
								state_d = S_SCAN;
							end
						end
						FN_ACTION: begin
							res = mk_res(ST_OK, 1'b1, act_ev, total_q, rc_q, 1'b1);
							if (rec_q && !ev_in.from_replay) begin
								if (total_q >= CNT_W'(STORE_DEPTH)) begin
									res.status = ST_FULL;
								end else begin
									ctrl.op = OP_WRITE;
									ctrl.pos = total_q[IDX_W-1:0];
									ctrl.ev = act_ev;
									total_d = total_q + CNT_W'(1);
									res.count = total_d;
								end
							end
						end
						FN_INSERT: begin
							if (total_q >= CNT_W'(STORE_DEPTH)) begin
								res = mk_res(ST_FULL, 1'b0, '0, total_q, rc_q, 1'b1);
							end else begin
								emit = 1'b0;
								mode_d = SM_PLACE;
								state_d = S_SCAN;
							end
						end
						FN_REWIND: begin
							rc_d = '0;
							ptr_d = '0;
							res = mk_res(ST_OK, 1'b0, '0, total_q, '0, 1'b1);
						end
						FN_CLEAR: begin
							total_d = '0;
							ptr_d = '0;
							res = mk_res(ST_OK, 1'b0, '0, '0, rc_q, 1'b1);
						end
						default: begin
							// delete and read
							if (32'(ev_in.slot) >= 32'(total_q)) begin
								res = mk_res(ST_BAD_IDX, 1'b0, '0, total_q, rc_q, 1'b1);
							end else begin
								emit = 1'b0;
								mode_d = SM_READ;
								state_d = S_SCAN;
							end
						end
					endcase
				end
			end

			S_SCAN: begin
				if (cnt_q == CNT_W'(STORE_DEPTH)) begin
					case (func_q)
						FN_READ: begin
							if (can_emit) begin
								emit = 1'b1;
								res = mk_res(ST_OK, 1'b0, head.ev, total_q, rc_q, 1'b1);
								state_d = S_IDLE;
							end
						end
						FN_DELETE: begin
							if (can_emit) begin
								ctrl.op = OP_REMOVE;
								ctrl.pos = slot_q;
								total_d = total_q - CNT_W'(1);
								if (ptr_q > CNT_W'(slot_q)) ptr_d = ptr_q - CNT_W'(1);
								emit = 1'b1;
								res = mk_res(ST_OK, 1'b0, head.ev, total_d, rc_q, 1'b1);
								state_d = S_IDLE;
							end
						end
						FN_INSERT: begin
							if (can_emit) begin
								ctrl.op = OP_INSERT;
								ctrl.pos = ins_pos[IDX_W-1:0];
								total_d = total_q + CNT_W'(1);
								emit = 1'b1;
								res = mk_res(ST_OK, 1'b0, item_q, total_d, rc_q, 1'b1);
								state_d = S_IDLE;
							end
						end
						default: begin
							// fetch: pointer search, then one read per event
							if (mode_q == SM_SKIP) begin
								ptr_d = head.hit ? CNT_W'(head.idx) : total_q;
								rd_d = ptr_d;
								n_d = '0;
								state_d = S_FETCH;
							end else if (head.ev.row == rc_q) begin
								if (n_q == '0 || can_emit) begin
									if (n_q != '0) begin
										emit = 1'b1;
										res = mk_res(ST_OK, 1'b0, held_q, total_q, rc_q, 1'b0);
									end
									held_d = head.ev;
									n_d = n_q + LIM_W'(1);
									rd_d = rd_q + CNT_W'(1);
									state_d = S_FETCH;
								end
							end else if (can_emit) begin
								emit = 1'b1;
								if (n_q == '0) begin
									res = mk_res(ST_NO_EVENT, 1'b0, '0, total_q, rc_q, 1'b1);
								end else begin
									res = mk_res(ST_OK, 1'b0, held_q, total_q, rc_q, 1'b1);
								end
								state_d = S_IDLE;
							end
						end
					endcase
				end
			end

			S_FETCH: begin
				if (rd_q < total_q && n_q < lim_q) begin
					mode_d = SM_READ;
					key_d = rd_q;
					cnt_d = '0;
					state_d = S_SCAN;
				end else if (can_emit) begin
					emit = 1'b1;
					if (n_q == '0) begin
						res = mk_res(ST_NO_EVENT, 1'b0, '0, total_q, rc_q, 1'b1);
					end else begin
						res = mk_res(ST_OK, 1'b0, held_q, total_q, rc_q, 1'b1);
					end
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// advance control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rc_q <= '0;
			ptr_q <= '0;
			total_q <= '0;
			rec_q <= 1'b0;
			play_q <= 1'b0;
			cnt_q <= '0;
			mode_q <= SM_READ;
			n_q <= '0;
			rd_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rc_q <= rc_d;
			ptr_q <= ptr_d;
			total_q <= total_d;
			cnt_q <= cnt_d;
			mode_q <= mode_d;
			n_q <= n_d;
			rd_q <= rd_d;
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_RECORD) rec_q <= cfg.data;
				else if (cfg.index == REG_PLAY) play_q <= cfg.data;
			end
			if (emit) out_valid_q <= 1'b1;
			else if (ev_out.ready) out_valid_q <= 1'b0;
		end
	end

	// hold command payload and result
	always_ff @(posedge clk) begin
		key_q <= key_d;
		func_q <= func_d;
		item_q <= item_d;
		slot_q <= slot_d;
		lim_q <= lim_d;
		held_q <= held_d;
		if (emit) res_q <= res;
	end

	// row of storage cells
	for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
		event_t left_ev;
		event_t right_ev;
		link_t  link_in;
		if (g == 0) begin : g_first
			assign left_ev = '0;
		end else begin : g_mid
			assign left_ev = cell_ev[g-1];
		end
		if (g == STORE_DEPTH - 1) begin : g_end
			assign right_ev = cell_ev[g];
			assign link_in = '0;
		end else begin : g_inner
			assign right_ev = cell_ev[g+1];
			assign link_in = cell_link[g+1];
		end
		ter_cell u_cell (
			.clk      (clk),
			.cell_idx (IDX_W'(g)),
			.ctrl     (ctrl),
			.left_ev  (left_ev),
			.right_ev (right_ev),
			.link_in  (link_in),
			.ev_q     (cell_ev[g]),
			.link_q   (cell_link[g])
		);
	end

	// drive result channel
	assign ev_out.valid = out_valid_q;
	assign ev_out.status = res_q.status;
	assign ev_out.execute = res_q.execute;
	assign ev_out.ev_row = res_q.ev.row;
	assign ev_out.ev_action = res_q.ev.code;
	assign ev_out.ev_param = res_q.ev.param;
	assign ev_out.ev_value = res_q.ev.value;
	assign ev_out.stored_count = 9'(res_q.count);
	assign ev_out.now_row = res_q.now;
	assign ev_out.order_number = res_q.now[ROW_W-1:ORDER_SHIFT];
	assign ev_out.row_in_order = res_q.now[ORDER_SHIFT-1:0];
	assign ev_out.last = res_q.last;

`ifndef NO_ASSERTIONS
	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= total_q) else $error("replay pointer beyond event count");
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(STORE_DEPTH)) else $error("event count beyond store depth");
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		(total_d != total_q && total_d != '0) |->
		(total_d == total_q + CNT_W'(1) || total_d == total_q - CNT_W'(1)))
		else $error("event count moved by more than one");
	a_no_emit_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !ev_out.ready) |-> !emit) else $error("result overwritten");
	a_scan_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STORE_DEPTH)) else $error("scan counter overran");
`endif
endmodule
`default_nettype wire
